### rtl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types, codes and helper functions for the toy language tokenizer:
// lexer mode codes, token kind codes, keyword table and start-state decode.
// ----------------------------------------------------------------------------
`default_nettype none

package tlt_pkg;

  // Default for the longest word that is still compared against keywords
  localparam int KeywordMaxLen = 6;

  // Lexer mode codes
  localparam int ModeW = 4;
  localparam logic [ModeW-1:0] ModeStart   = 4'd0;
  localparam logic [ModeW-1:0] ModeIdent   = 4'd1;
  localparam logic [ModeW-1:0] ModeNumber  = 4'd2;
  localparam logic [ModeW-1:0] ModeString  = 4'd3;
  localparam logic [ModeW-1:0] ModeEscape  = 4'd4;
  localparam logic [ModeW-1:0] ModeComment = 4'd5;
  localparam logic [ModeW-1:0] ModePendEq  = 4'd6;
  localparam logic [ModeW-1:0] ModePendNot = 4'd7;
  localparam logic [ModeW-1:0] ModePendLt  = 4'd8;
  localparam logic [ModeW-1:0] ModePendGt  = 4'd9;

  // Token kind codes
  localparam int KindW = 5;
  localparam logic [KindW-1:0] TokIdent   = 5'd8;
  localparam logic [KindW-1:0] TokIntLit  = 5'd9;
  localparam logic [KindW-1:0] TokStrLit  = 5'd10;
  localparam logic [KindW-1:0] TokPlus    = 5'd11;
  localparam logic [KindW-1:0] TokMinus   = 5'd12;
  localparam logic [KindW-1:0] TokStar    = 5'd13;
  localparam logic [KindW-1:0] TokSlash   = 5'd14;
  localparam logic [KindW-1:0] TokAssign  = 5'd15;
  localparam logic [KindW-1:0] TokEqEq    = 5'd16;
  localparam logic [KindW-1:0] TokNotEq   = 5'd17;
  localparam logic [KindW-1:0] TokLt      = 5'd18;
  localparam logic [KindW-1:0] TokLe      = 5'd19;
  localparam logic [KindW-1:0] TokGt      = 5'd20;
  localparam logic [KindW-1:0] TokGe      = 5'd21;
  localparam logic [KindW-1:0] TokLParen  = 5'd22;
  localparam logic [KindW-1:0] TokRParen  = 5'd23;
  localparam logic [KindW-1:0] TokLBrace  = 5'd24;
  localparam logic [KindW-1:0] TokRBrace  = 5'd25;
  localparam logic [KindW-1:0] TokSemi    = 5'd26;
  localparam logic [KindW-1:0] TokComma   = 5'd27;
  localparam logic [KindW-1:0] TokEof     = 5'd28;
  localparam logic [KindW-1:0] TokError   = 5'd29;

  // Keyword table, kind code equals the row index
  localparam int KwCount   = 8;
  localparam int KwTextLen = 6;
  localparam logic [7:0] KwText [KwCount][KwTextLen] = '{
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g"}
  };
  localparam logic [2:0] KwLen [KwCount] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd6, 3'd3, 3'd6
  };

  // One result item
  typedef struct packed {
    logic             is_text;
    logic [7:0]       text_byte;
    logic [KindW-1:0] token_kind;
  } res_t;

  // Result item plus its end marker, as held in the output buffer
  typedef struct packed {
    res_t res;
    logic last;
  } out_t;

  // Outcome of decoding a byte in the start state
  typedef struct packed {
    logic             emit;
    res_t             res;
    logic [ModeW-1:0] mode;
    logic             word_start;
  } disp_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic res_t tok_res(input logic [KindW-1:0] kind);
    res_t r;
    r = '0;
    r.token_kind = kind;
    return r;
  endfunction

  function automatic res_t text_res(input logic [7:0] b);
    res_t r;
    r = '0;
    r.is_text   = 1'b1;
    r.text_byte = b;
    return r;
  endfunction

  // Decode one byte from the start state
  function automatic disp_t tok_dispatch(input logic [7:0] c);
    disp_t d;
    d      = '0;
    d.mode = ModeStart;
    case (c) inside
      " ", "\t", "\n", "\r": begin
      end
      "=": d.mode = ModePendEq;
      "!": d.mode = ModePendNot;
      "<": d.mode = ModePendLt;
      ">": d.mode = ModePendGt;
      "#": d.mode = ModeComment;
      "\"": d.mode = ModeString;
      "+": begin d.emit = 1'b1; d.res = tok_res(TokPlus); end
      "-": begin d.emit = 1'b1; d.res = tok_res(TokMinus); end
      "*": begin d.emit = 1'b1; d.res = tok_res(TokStar); end
      "/": begin d.emit = 1'b1; d.res = tok_res(TokSlash); end
      "(": begin d.emit = 1'b1; d.res = tok_res(TokLParen); end
      ")": begin d.emit = 1'b1; d.res = tok_res(TokRParen); end
      "{": begin d.emit = 1'b1; d.res = tok_res(TokLBrace); end
      "}": begin d.emit = 1'b1; d.res = tok_res(TokRBrace); end
      ";": begin d.emit = 1'b1; d.res = tok_res(TokSemi); end
      ",": begin d.emit = 1'b1; d.res = tok_res(TokComma); end
      8'h00: begin d.emit = 1'b1; d.res = tok_res(TokEof); end
      default: begin
        d.emit = 1'b1;
        if (is_letter(c)) begin
          d.mode       = ModeIdent;
          d.word_start = 1'b1;
          d.res        = text_res(c);
        end else if (is_digit(c)) begin
          d.mode = ModeNumber;
          d.res  = text_res(c);
        end else begin
          d.res = tok_res(TokError);
        end
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/toy_language_tokenizer_core.sv
// ----------------------------------------------------------------------------
// toy_language_tokenizer_core
// Streaming lexer: one source byte per input transfer, up to two result items
// (text bytes or token completions) per byte on the output stream.
// ----------------------------------------------------------------------------
// Output: results are registered; the first result of a byte is valid in the cycle after its input transfer.
// Throughput: one byte per cycle while each byte yields at most one result and
//   the output is not stalled; a byte that yields two results blocks the input
//   while both are buffered, and the next byte is taken together with the transfer of the second result.
// Reset: lexer returns to the start state, word length clears, result buffer
//   empties; the word buffer itself is not reset.
`default_nettype none

module toy_language_tokenizer_core #(
  parameter int KEYWORD_MAX_LEN = tlt_pkg::KeywordMaxLen
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] text_byte, [12:8] token_kind
  output logic             m_axis_tuser,   // [0] is_text
  output logic             m_axis_tlast    // last result of this byte
);

  localparam int LenW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int IdxW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [LenW-1:0] LenMax  = LenW'(KEYWORD_MAX_LEN);
  localparam logic [LenW-1:0] LenOver = LenW'(KEYWORD_MAX_LEN + 1);

  // Lexer state
  logic [tlt_pkg::ModeW-1:0] mode_q, mode_d;
  logic [LenW-1:0]           len_q, len_d;
  logic [7:0]                word_q [KEYWORD_MAX_LEN];
  logic                      word_we;
  logic [IdxW-1:0]           word_idx;

  // Result buffer
  tlt_pkg::out_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic          v0_q, v0_d, v1_q, v1_d;

  // Per-byte results
  tlt_pkg::res_t  r0, r1;
  logic           r0_vld, r1_vld;
  tlt_pkg::disp_t disp;
  logic [tlt_pkg::KindW-1:0] kw_kind;
  logic [7:0]     c;
  logic           in_fire, out_fire;
  logic           push, start;

  assign c        = s_axis_tdata;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = v0_q && m_axis_tready;

  // Take a byte once the buffer is empty or drains this cycle
  assign s_axis_tready = !v0_q || (m_axis_tready && !v1_q);

  assign disp = tlt_pkg::tok_dispatch(c);

  // Compare the held word against the keyword table
  always_comb begin
    logic hit;
    kw_kind = tlt_pkg::TokIdent;
    for (int k = tlt_pkg::KwCount - 1; k >= 0; k--) begin
      hit = (len_q == LenW'(tlt_pkg::KwLen[k]));
      for (int i = 0; i < tlt_pkg::KwTextLen; i++) begin
        if ((i < int'(tlt_pkg::KwLen[k])) && (word_q[i] != tlt_pkg::KwText[k][i])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kw_kind = tlt_pkg::KindW'(k);
      end
    end
  end

  // Mode transition and result selection
  always_comb begin
    mode_d = mode_q;
    r0     = '0;
    r1     = '0;
    r0_vld = 1'b0;
    r1_vld = 1'b0;
    push   = 1'b0;
    start  = 1'b0;
    unique case (mode_q)
      tlt_pkg::ModeIdent: begin
        if (tlt_pkg::is_letter(c)) begin
          push   = 1'b1;
          r0_vld = 1'b1;
          r0     = tlt_pkg::text_res(c);
        end else begin
          r0_vld = 1'b1;
          r0     = tlt_pkg::tok_res(kw_kind);
          r1_vld = disp.emit;
          r1     = disp.res;
          mode_d = disp.mode;
          start  = disp.word_start;
        end
      end
      tlt_pkg::ModeNumber: begin
        r0_vld = 1'b1;
        if (tlt_pkg::is_digit(c)) begin
          r0 = tlt_pkg::text_res(c);
        end else begin
          r0     = tlt_pkg::tok_res(tlt_pkg::TokIntLit);
          r1_vld = disp.emit;
          r1     = disp.res;
          mode_d = disp.mode;
          start  = disp.word_start;
        end
      end
      tlt_pkg::ModeString: begin
        if (c == "\"") begin
          r0_vld = 1'b1;
          r0     = tlt_pkg::tok_res(tlt_pkg::TokStrLit);
          mode_d = tlt_pkg::ModeStart;
        end else if (c == 8'h00) begin
          r0_vld = 1'b1;
          r0     = tlt_pkg::tok_res(tlt_pkg::TokStrLit);
          r1_vld = 1'b1;
          r1     = tlt_pkg::tok_res(tlt_pkg::TokEof);
          mode_d = tlt_pkg::ModeStart;
        end else if (c == "\\") begin
          mode_d = tlt_pkg::ModeEscape;
        end else begin
          r0_vld = 1'b1;
          r0     = tlt_pkg::text_res(c);
        end
      end
      tlt_pkg::ModeEscape: begin
        r0_vld = 1'b1;
        if (c == 8'h00) begin
          r0     = tlt_pkg::tok_res(tlt_pkg::TokStrLit);
          r1_vld = 1'b1;
          r1     = tlt_pkg::tok_res(tlt_pkg::TokEof);
          mode_d = tlt_pkg::ModeStart;
        end else begin
          mode_d = tlt_pkg::ModeString;
          if (c == "n") begin
            r0 = tlt_pkg::text_res(8'h0A);
          end else if (c == "t") begin
            r0 = tlt_pkg::text_res(8'h09);
          end else if (c == "r") begin
            r0 = tlt_pkg::text_res(8'h0D);
          end else begin
            r0 = tlt_pkg::text_res(c);
          end
        end
      end
      tlt_pkg::ModeComment: begin
        if (c == "\n") begin
          mode_d = tlt_pkg::ModeStart;
        end else if (c == 8'h00) begin
          r0_vld = 1'b1;
          r0     = tlt_pkg::tok_res(tlt_pkg::TokEof);
          mode_d = tlt_pkg::ModeStart;
        end
      end
      tlt_pkg::ModePendEq, tlt_pkg::ModePendNot,
      tlt_pkg::ModePendLt, tlt_pkg::ModePendGt: begin
        r0_vld = 1'b1;
        if (c == "=") begin
          mode_d = tlt_pkg::ModeStart;
          unique case (mode_q)
            tlt_pkg::ModePendEq:  r0 = tlt_pkg::tok_res(tlt_pkg::TokEqEq);
            tlt_pkg::ModePendNot: r0 = tlt_pkg::tok_res(tlt_pkg::TokNotEq);
            tlt_pkg::ModePendLt:  r0 = tlt_pkg::tok_res(tlt_pkg::TokLe);
            default:              r0 = tlt_pkg::tok_res(tlt_pkg::TokGe);
          endcase
        end else begin
          unique case (mode_q)
            tlt_pkg::ModePendEq:  r0 = tlt_pkg::tok_res(tlt_pkg::TokAssign);
            tlt_pkg::ModePendNot: r0 = tlt_pkg::tok_res(tlt_pkg::TokError);
            tlt_pkg::ModePendLt:  r0 = tlt_pkg::tok_res(tlt_pkg::TokLt);
            default:              r0 = tlt_pkg::tok_res(tlt_pkg::TokGt);
          endcase
          r1_vld = disp.emit;
          r1     = disp.res;
          mode_d = disp.mode;
          start  = disp.word_start;
        end
      end
      default: begin
        r0_vld = disp.emit;
        r0     = disp.res;
        mode_d = disp.mode;
        start  = disp.word_start;
      end
    endcase
  end

  // Word buffer write and length update
  always_comb begin
    len_d    = len_q;
    word_we  = 1'b0;
    word_idx = '0;
    if (start) begin
      word_we = 1'b1;
      len_d   = LenW'(1);
    end else if (push) begin
      if (len_q < LenMax) begin
        word_we  = 1'b1;
        word_idx = len_q[IdxW-1:0];
        len_d    = len_q + LenW'(1);
      end else begin
        len_d = LenOver;
      end
    end
  end

  // Result buffer: load on input transfer, else shift on output transfer
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    v0_d    = v0_q;
    v1_d    = v1_q;
    if (in_fire) begin
      v0_d         = r0_vld;
      v1_d         = r1_vld;
      slot0_d.res  = r0;
      slot0_d.last = !r1_vld;
      slot1_d.res  = r1;
      slot1_d.last = 1'b1;
    end else if (out_fire) begin
      v0_d    = v1_q;
      slot0_d = slot1_q;
      v1_d    = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tlt_pkg::ModeStart;
      len_q  <= '0;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      if (in_fire) begin
        mode_q <= mode_d;
        len_q  <= len_d;
      end
    end
  end

  // Payload: word letters and buffered results
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
    if (in_fire && word_we) begin
      word_q[word_idx] <= c;
    end
  end

  assign m_axis_tvalid = v0_q;
  assign m_axis_tdata  = {3'b000, slot0_q.res.token_kind, slot0_q.res.text_byte};
  assign m_axis_tuser  = slot0_q.res.is_text;
  assign m_axis_tlast  = slot0_q.last;

  // Second slot only fills behind the first
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q)
    else $error("second result slot valid while first is empty");

  // A lone buffered result always closes its byte
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && !v1_q) |-> slot0_q.last)
    else $error("sole buffered result lacks end marker");

  // First of two results never closes its byte
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (!slot0_q.last && slot1_q.last))
    else $error("end markers wrong on a result pair");

  // Word length saturates one past the compare limit
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenOver)
    else $error("word length beyond saturation value");

  // No byte is taken while a result pair is still waiting
  a_no_take_on_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> !s_axis_tready)
    else $error("input taken with two results pending");

endmodule

`default_nettype wire

### dv/toy_language_tokenizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// toy_language_tokenizer_core_tb
// Self-checking bench for the streaming lexer. Source bytes go in on the input
// stream while a lexer model tracks mode, word buffer and keyword match. Each
// output transfer is checked against the oldest queued token or text result.
// The stimulus is a directed set of corner cases followed by random token
// streams, run under several source and sink idle mixes and one long sink
// stall.
// ----------------------------------------------------------------------------

module toy_language_tokenizer_core_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;   // [7:0] text_byte, [12:8] token_kind
  logic        m_axis_tuser;   // [0] is_text
  logic        m_axis_tlast;

  // Lexer model state
  logic [tlt_pkg::ModeW-1:0] lex_mode = tlt_pkg::ModeStart;
  logic [7:0]       word_buf [tlt_pkg::KeywordMaxLen];
  int unsigned      word_len = 0;
  tlt_pkg::out_t    byte_results [$];
  tlt_pkg::out_t    token_stream_q [$];
  int unsigned      sent_bytes = 0;
  int unsigned      mismatch_count = 0;

  // Flow control knobs
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned stall_req = 0;
  int unsigned stall_left = 0;

  string op_text [18] = '{"+", "-", "*", "/", "(", ")", "{", "}", ";", ",",
                          "=", "==", "!=", "<", "<=", ">", ">=", "!"};

  toy_language_tokenizer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Lexer model
  function automatic bit is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic void push_result(input bit txt, input logic [7:0] b,
                                      input logic [tlt_pkg::KindW-1:0] k);
    tlt_pkg::out_t r;
    if (byte_results.size() >= 2) return;
    r = '0;
    r.res.is_text    = txt;
    r.res.text_byte  = b;
    r.res.token_kind = k;
    byte_results.push_back(r);
  endfunction

  // Keyword code of the buffered word, or plain identifier
  function automatic logic [tlt_pkg::KindW-1:0] word_kind();
    bit hit;
    for (int k = 0; k < tlt_pkg::KwCount; k++) begin
      if (tlt_pkg::KwLen[k] == word_len && word_len <= tlt_pkg::KeywordMaxLen) begin
        hit = 1'b1;
        for (int i = 0; i < tlt_pkg::KwLen[k]; i++) begin
          if (word_buf[i] != tlt_pkg::KwText[k][i]) hit = 1'b0;
        end
        if (hit) return tlt_pkg::KindW'(k);
      end
    end
    return tlt_pkg::TokIdent;
  endfunction

  // Append a letter; saturate the length once the buffer is full
  function automatic void word_push(input logic [7:0] c);
    if (word_len < tlt_pkg::KeywordMaxLen) begin
      word_buf[word_len] = c;
      word_len++;
    end else begin
      word_len = tlt_pkg::KeywordMaxLen + 1;
    end
  endfunction

  // Handle a byte as if in the start state
  function automatic void lex_start(input logic [7:0] c);
    lex_mode = tlt_pkg::ModeStart;
    case (c)
      " ", "\t", "\n", "\r": begin
      end
      "=": lex_mode = tlt_pkg::ModePendEq;
      "!": lex_mode = tlt_pkg::ModePendNot;
      "<": lex_mode = tlt_pkg::ModePendLt;
      ">": lex_mode = tlt_pkg::ModePendGt;
      "#": lex_mode = tlt_pkg::ModeComment;
      "\"": lex_mode = tlt_pkg::ModeString;
      "+": push_result(1'b0, 8'h00, tlt_pkg::TokPlus);
      "-": push_result(1'b0, 8'h00, tlt_pkg::TokMinus);
      "*": push_result(1'b0, 8'h00, tlt_pkg::TokStar);
      "/": push_result(1'b0, 8'h00, tlt_pkg::TokSlash);
      "(": push_result(1'b0, 8'h00, tlt_pkg::TokLParen);
      ")": push_result(1'b0, 8'h00, tlt_pkg::TokRParen);
      "{": push_result(1'b0, 8'h00, tlt_pkg::TokLBrace);
      "}": push_result(1'b0, 8'h00, tlt_pkg::TokRBrace);
      ";": push_result(1'b0, 8'h00, tlt_pkg::TokSemi);
      ",": push_result(1'b0, 8'h00, tlt_pkg::TokComma);
      8'h00: push_result(1'b0, 8'h00, tlt_pkg::TokEof);
      default: begin
        if (is_alpha(c)) begin
          lex_mode = tlt_pkg::ModeIdent;
          word_len = 0;
          word_push(c);
          push_result(1'b1, c, '0);
        end else if (is_num(c)) begin
          lex_mode = tlt_pkg::ModeNumber;
          push_result(1'b1, c, '0);
        end else begin
          push_result(1'b0, 8'h00, tlt_pkg::TokError);
        end
      end
    endcase
  endfunction

  // Resolve a pending one-character operator
  function automatic void lex_pending(input logic [7:0] c,
                                      input logic [tlt_pkg::KindW-1:0] pair,
                                      input logic [tlt_pkg::KindW-1:0] single);
    if (c == "=") begin
      push_result(1'b0, 8'h00, pair);
      lex_mode = tlt_pkg::ModeStart;
    end else begin
      push_result(1'b0, 8'h00, single);
      lex_start(c);
    end
  endfunction

  // Advance the model by one source byte and queue what it yields
  function automatic void lex_byte(input logic [7:0] c);
    tlt_pkg::out_t r;
    logic [7:0]    esc;
    byte_results.delete();
    case (lex_mode)
      tlt_pkg::ModeIdent: begin
        if (is_alpha(c)) begin
          word_push(c);
          push_result(1'b1, c, '0);
        end else begin
          push_result(1'b0, 8'h00, word_kind());
          lex_start(c);
        end
      end
      tlt_pkg::ModeNumber: begin
        if (is_num(c)) begin
          push_result(1'b1, c, '0);
        end else begin
          push_result(1'b0, 8'h00, tlt_pkg::TokIntLit);
          lex_start(c);
        end
      end
      tlt_pkg::ModeString: begin
        if (c == "\"") begin
          push_result(1'b0, 8'h00, tlt_pkg::TokStrLit);
          lex_mode = tlt_pkg::ModeStart;
        end else if (c == 8'h00) begin
          push_result(1'b0, 8'h00, tlt_pkg::TokStrLit);
          push_result(1'b0, 8'h00, tlt_pkg::TokEof);
          lex_mode = tlt_pkg::ModeStart;
        end else if (c == "\\") begin
          lex_mode = tlt_pkg::ModeEscape;
        end else begin
          push_result(1'b1, c, '0);
        end
      end
      tlt_pkg::ModeEscape: begin
        if (c == 8'h00) begin
          push_result(1'b0, 8'h00, tlt_pkg::TokStrLit);
          push_result(1'b0, 8'h00, tlt_pkg::TokEof);
          lex_mode = tlt_pkg::ModeStart;
        end else begin
          esc = c;
          if (c == "n") esc = "\n";
          else if (c == "t") esc = "\t";
          else if (c == "r") esc = "\r";
          push_result(1'b1, esc, '0);
          lex_mode = tlt_pkg::ModeString;
        end
      end
      tlt_pkg::ModeComment: begin
        if (c == "\n") begin
          lex_mode = tlt_pkg::ModeStart;
        end else if (c == 8'h00) begin
          push_result(1'b0, 8'h00, tlt_pkg::TokEof);
          lex_mode = tlt_pkg::ModeStart;
        end
      end
      tlt_pkg::ModePendEq:  lex_pending(c, tlt_pkg::TokEqEq, tlt_pkg::TokAssign);
      tlt_pkg::ModePendNot: lex_pending(c, tlt_pkg::TokNotEq, tlt_pkg::TokError);
      tlt_pkg::ModePendLt:  lex_pending(c, tlt_pkg::TokLe, tlt_pkg::TokLt);
      tlt_pkg::ModePendGt:  lex_pending(c, tlt_pkg::TokGe, tlt_pkg::TokGt);
      default:              lex_start(c);
    endcase
    foreach (byte_results[i]) begin
      r = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      token_stream_q.push_back(r);
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    if (mismatch_count < 10) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endfunction

  // Track input transfers into the model, check every output transfer
  always @(posedge clk_i) begin : stream_monitor
    tlt_pkg::out_t want;
    logic [15:0]   want_data;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (token_stream_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%04h tuser=%0b tlast=%0b",
                                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want      = token_stream_q.pop_front();
          want_data = {3'b000, want.res.token_kind, want.res.text_byte};
          if (m_axis_tdata !== want_data || m_axis_tuser !== want.res.is_text ||
              m_axis_tlast !== want.last) begin
            report_mismatch($sformatf(
              {"mismatch: expected is_text=%0b byte=%02h kind=%0d last=%0b, ",
               "got is_text=%0b byte=%02h kind=%0d last=%0b pad=%0h"},
              want.res.is_text, want.res.text_byte, want.res.token_kind, want.last,
              m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8], m_axis_tlast,
              m_axis_tdata[15:13]));
          end
        end
      end
    end
  end

  // Sink: random back-pressure, or a long hold when one is requested
  always @(negedge clk_i) begin
    if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req  = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Offer one byte, with random idle cycles first, and hold until the transfer
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  // Any nonzero byte except the quote and the backslash
  function automatic logic [7:0] rand_string_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == "\"" || b == "\\");
    return b;
  endfunction

  // Emit one well-formed token with random content, or some noise
  task automatic send_random_token();
    int unsigned pick;
    int unsigned k;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // keyword, sometimes stretched into a longer word
      k = $urandom_range(0, tlt_pkg::KwCount - 1);
      for (int i = 0; i < tlt_pkg::KwLen[k]; i++) send_char(tlt_pkg::KwText[k][i]);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_char(rand_letter());
    end else if (pick < 27) begin
      repeat ($urandom_range(1, 9)) send_char(rand_letter());
    end else if (pick < 37) begin
      repeat ($urandom_range(1, 5)) send_char(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 49) begin
      send_char("\"");
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 3) == 0) begin
          send_char("\\");
          case ($urandom_range(0, 5))
            0: send_char("n");
            1: send_char("t");
            2: send_char("r");
            3: send_char("\\");
            4: send_char("\"");
            default: send_char(rand_string_byte());
          endcase
        end else begin
          send_char(rand_string_byte());
        end
      end
      // close it, or cut it off at end of input
      case ($urandom_range(0, 19))
        0: send_char(8'h00);
        1: begin
          send_char("\\");
          send_char(8'h00);
        end
        default: send_char("\"");
      endcase
    end else if (pick < 54) begin
      send_char("#");
      repeat ($urandom_range(0, 6)) begin
        do b = 8'($urandom_range(1, 255)); while (b == "\n");
        send_char(b);
      end
      send_char(($urandom_range(0, 9) == 0) ? 8'h00 : 8'h0a);
    end else if (pick < 79) begin
      send_text(op_text[$urandom_range(0, 17)]);
    end else if (pick < 89) begin
      case ($urandom_range(0, 3))
        0: send_char(" ");
        1: send_char("\t");
        2: send_char("\n");
        default: send_char("\r");
      endcase
    end else if (pick < 94) begin
      send_char(8'h00);
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Send random tokens until about count more bytes went in
  task automatic send_random_tokens(input int unsigned count);
    int unsigned goal;
    goal = sent_bytes + count;
    while (sent_bytes < goal) send_random_token();
  endtask

  // Seven-letter word misses "string"; a digit ends it and starts a number
  task automatic test_long_word();
    send_text("strings9");
  endtask

  // Two-character operators, an operator ended by another, a lone bang
  task automatic test_operators();
    send_text("!=<>=!a");
  endtask

  // Escapes inside a string (known and unknown), then a comment line
  task automatic test_strings_and_comments();
    send_text("\"\\n\\q\"#\n");
  endtask

  // Bytes outside the language, top bit set
  task automatic test_bad_bytes();
    send_char(8'h80);
    send_char(8'hff);
  endtask

  // End of input after a dangling escape, inside a comment, after a word
  task automatic test_end_of_input();
    send_text("\"\\");
    send_char(8'h00);
    send_char("#");
    send_char(8'h00);
    send_char("x");
    send_char(8'h00);
  endtask

  // Hold the sink off while the source keeps offering bytes
  task automatic test_output_stall();
    stall_req = 400;
    send_random_tokens(40);
  endtask

  task automatic test_random_stream(input int unsigned src_pct, input int unsigned sink_pct,
                                    input int unsigned count);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    send_random_tokens(count);
  endtask

  initial begin : main_sequence
    int unsigned guard;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    src_idle_pct  = 15;
    sink_idle_pct = 59;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_long_word();
    test_operators();
    test_strings_and_comments();
    test_bad_bytes();
    test_end_of_input();
    test_random_stream(15, 59, 360);
    test_output_stall();
    test_random_stream(59, 15, 360);
    test_random_stream(0, 0, 360);

    // Drain what is still in flight
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (token_stream_q.size() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (token_stream_q.size() > 0) begin
      $display("%0d results never arrived", token_stream_q.size());
      mismatch_count += token_stream_q.size();
    end

    if (mismatch_count == 0) begin
      $display("** toy_language_tokenizer_core: PASSED **");
    end else begin
      $display("** toy_language_tokenizer_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** toy_language_tokenizer_core: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/tlt_pkg.sv
rtl/toy_language_tokenizer_core.sv
dv/toy_language_tokenizer_core_tb.sv
